/* rtl/lcf_pkg.sv */
// shared constants and types for the linear convolution fir
`default_nettype none

package lcf_pkg;

    localparam int MAX_TAPS_DEF = 16;
    localparam int DATA_W       = 32;
    localparam int KLEN_W       = 5;
    localparam int IDX_W        = 4;
    localparam int S_TDATA_W    = 40;

    typedef enum logic [0:0] {
        CMD_SAMPLE = 1'b0,
        CMD_LOAD   = 1'b1
    } cmd_t;

    typedef enum logic [0:0] {
        ST_RUN   = 1'b0,
        ST_FLUSH = 1'b1
    } state_t;

    typedef struct packed {
        logic valid;
        logic last;
    } tag_t;

endpackage

`default_nettype wire

/* rtl/linear_convolution_fir.sv */
// top level of the streaming full linear convolution fir
//
// Streaming FIR that computes the full linear convolution of unsigned 32-bit
// words, all sums modulo 2^32. A load transfer (tuser = 1) writes coefficient
// coef_index and gives no result; a sample transfer (tuser = 0) shifts into a
// row of MAX_TAPS tap cells and gives one result. One sample is taken per clock
// while the result queue has credit; each result passes through the registered
// tap product, the registered adder tree and the result queue to the master side.
// A sample with tlast set is followed by kernel_length - 1 zero flush results,
// one per cycle while credit lasts, with s_tready low; the delay line is cleared
// afterwards and the final result carries m_tlast. A result queue of
// 2^clog2(clog2(MAX_TAPS) + 3) entries decouples m_tready from s_tready.
// kernel_length is taken as 1 when written 0 and as MAX_TAPS above that.
`default_nettype none

module linear_convolution_fir #(
    parameter int MAX_TAPS = lcf_pkg::MAX_TAPS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [lcf_pkg::KLEN_W-1:0]    cfg_wr_data,  // kernel_length
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [lcf_pkg::S_TDATA_W-1:0] s_tdata,      // value, coef_index
    input  wire logic                          s_tlast,      // last_sample
    input  wire logic [0:0]                    s_tuser,      // command
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [lcf_pkg::DATA_W-1:0]    m_tdata,      // result
    output logic                               m_tlast       // last_result
);

    localparam int CNT_W       = $clog2(MAX_TAPS + 1);
    localparam int TREE_LEVELS = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int FIFO_DEPTH  = 1 << $clog2(TREE_LEVELS + 3);
    localparam int PEND_W      = $clog2(FIFO_DEPTH + 1);

    lcf_pkg::state_t              state_reg;
    lcf_pkg::state_t              state_next;
    logic [CNT_W-1:0]             taps_reg;
    logic [CNT_W-1:0]             taps_next;
    logic [CNT_W-1:0]             flush_cnt_reg;
    logic [CNT_W-1:0]             flush_cnt_next;
    logic [PEND_W-1:0]            pending_reg;
    logic [PEND_W-1:0]            pending_next;
    lcf_pkg::tag_t                issue_tag_reg;
    lcf_pkg::tag_t                issue_tag_next;

    logic                         credit_ok;
    logic                         s_xfer;
    logic                         sample_xfer;
    logic                         load_xfer;
    logic                         flush_step;
    logic                         issue;
    logic                         seq_end;
    logic                         m_xfer;
    logic [lcf_pkg::DATA_W-1:0]   s_value;
    logic [lcf_pkg::IDX_W-1:0]    s_coef_index;
    logic [lcf_pkg::DATA_W-1:0]   shift_data;

    logic [lcf_pkg::DATA_W-1:0]   hist   [MAX_TAPS];
    logic [lcf_pkg::DATA_W-1:0]   prod   [MAX_TAPS];
    logic [lcf_pkg::DATA_W-1:0]   tree_sum;
    lcf_pkg::tag_t                tree_tag;

    assign s_value      = s_tdata[lcf_pkg::DATA_W-1:0];
    assign s_coef_index = s_tdata[lcf_pkg::DATA_W +: lcf_pkg::IDX_W];

    assign credit_ok   = (pending_reg < PEND_W'(FIFO_DEPTH));
    assign s_xfer      = s_tvalid && s_tready;
    assign sample_xfer = s_xfer && (s_tuser[0] == lcf_pkg::CMD_SAMPLE);
    assign load_xfer   = s_xfer && (s_tuser[0] == lcf_pkg::CMD_LOAD);
    assign issue       = sample_xfer || flush_step;
    assign m_xfer      = m_tvalid && m_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lcf_pkg::ST_RUN: begin
                if (sample_xfer && s_tlast && taps_reg != CNT_W'(1)) begin
                    state_next = lcf_pkg::ST_FLUSH;
                end
            end
            lcf_pkg::ST_FLUSH: begin
                if (flush_step && flush_cnt_reg == CNT_W'(1)) begin
                    state_next = lcf_pkg::ST_RUN;
                end
            end
            default: state_next = lcf_pkg::ST_RUN;
        endcase
    end

    // state outputs
    always_comb begin
        s_tready   = 1'b0;
        flush_step = 1'b0;
        shift_data = s_value;
        seq_end    = 1'b0;
        unique case (state_reg)
            lcf_pkg::ST_RUN: begin
                s_tready = credit_ok;
                seq_end  = s_tlast && taps_reg == CNT_W'(1);
            end
            lcf_pkg::ST_FLUSH: begin
                flush_step = credit_ok;
                shift_data = '0;
                seq_end    = (flush_cnt_reg == CNT_W'(1));
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb begin
        taps_next = taps_reg;
        if (cfg_wr_en) begin
            if (cfg_wr_data == '0) begin
                taps_next = CNT_W'(1);
            end else if (32'(cfg_wr_data) > MAX_TAPS) begin
                taps_next = CNT_W'(MAX_TAPS);
            end else begin
                taps_next = CNT_W'(cfg_wr_data);
            end
        end

        flush_cnt_next = flush_cnt_reg;
        if (sample_xfer && s_tlast) begin
            flush_cnt_next = taps_reg - CNT_W'(1);
        end else if (flush_step) begin
            flush_cnt_next = flush_cnt_reg - CNT_W'(1);
        end

        pending_next = pending_reg + PEND_W'(issue) - PEND_W'(m_xfer);

        issue_tag_next.valid = issue;
        issue_tag_next.last  = issue && seq_end;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= lcf_pkg::ST_RUN;
            taps_reg      <= CNT_W'(1);
            flush_cnt_reg <= '0;
            pending_reg   <= '0;
            issue_tag_reg <= '0;
        end else begin
            state_reg     <= state_next;
            taps_reg      <= taps_next;
            flush_cnt_reg <= flush_cnt_next;
            pending_reg   <= pending_next;
            issue_tag_reg <= issue_tag_next;
        end
    end

    genvar j;
    generate
        for (j = 0; j < MAX_TAPS; j++) begin : g_tap
            logic [lcf_pkg::DATA_W-1:0] sample_in;
            logic                       coef_we;
            logic                       tap_en;

            if (j == 0) begin : g_head
                assign sample_in = shift_data;
            end else begin : g_body
                assign sample_in = hist[j-1];
            end

            assign coef_we = load_xfer && (32'(s_coef_index) == j);
            assign tap_en  = (32'(taps_reg) > j);

            lcf_tap_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .shift_en   (issue),
                .clear      (issue && seq_end),
                .sample_in  (sample_in),
                .coef_we    (coef_we),
                .coef_data  (s_value),
                .tap_en     (tap_en),
                .sample_out (hist[j]),
                .prod_out   (prod[j])
            );
        end
    endgenerate

    lcf_adder_tree #(
        .NUM_LEAVES (MAX_TAPS)
    ) u_tree (
        .aclk    (aclk),
        .aresetn (aresetn),
        .leaf    (prod),
        .tag_in  (issue_tag_reg),
        .sum_out (tree_sum),
        .tag_out (tree_tag)
    );

    lcf_out_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (tree_tag.valid),
        .wr_result (tree_sum),
        .wr_last   (tree_tag.last),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

`ifndef NO_ASSERTIONS
    a_pending_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg <= PEND_W'(FIFO_DEPTH))
        else $error("results in flight exceed queue depth");

    a_flush_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == lcf_pkg::ST_FLUSH |-> !s_tready)
        else $error("input taken during flush");

    a_flush_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (flush_step && flush_cnt_reg == CNT_W'(1)) |=> state_reg == lcf_pkg::ST_RUN)
        else $error("flush did not end after last zero");

    a_result_has_credit: assert property (@(posedge aclk) disable iff (!aresetn)
        tree_tag.valid |-> pending_reg != '0)
        else $error("result arrived without an issued transfer");
`endif

endmodule

`default_nettype wire

/* rtl/lcf_tap_cell.sv */
// one tap of the delay line: sample, coefficient and registered product
`default_nettype none

module lcf_tap_cell (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      shift_en,
    input  wire logic                      clear,
    input  wire logic [lcf_pkg::DATA_W-1:0] sample_in,
    input  wire logic                      coef_we,
    input  wire logic [lcf_pkg::DATA_W-1:0] coef_data,
    input  wire logic                      tap_en,
    output logic      [lcf_pkg::DATA_W-1:0] sample_out,
    output logic      [lcf_pkg::DATA_W-1:0] prod_out
);

    logic [lcf_pkg::DATA_W-1:0]   hist_reg;
    logic [lcf_pkg::DATA_W-1:0]   hist_next;
    logic [lcf_pkg::DATA_W-1:0]   hist_shifted;
    logic [lcf_pkg::DATA_W-1:0]   coef_reg;
    logic [lcf_pkg::DATA_W-1:0]   coef_gated;
    logic [2*lcf_pkg::DATA_W-1:0] prod_full;
    logic [lcf_pkg::DATA_W-1:0]   prod_reg;
    logic [lcf_pkg::DATA_W-1:0]   prod_next;

    always_comb begin
        hist_shifted = shift_en ? sample_in : hist_reg;
        hist_next    = clear ? '0 : hist_shifted;
        coef_gated   = tap_en ? coef_reg : '0;
        prod_full    = coef_gated * hist_shifted;
        prod_next    = prod_full[lcf_pkg::DATA_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg <= '0;
            coef_reg <= '0;
        end else begin
            hist_reg <= hist_next;
            if (coef_we) begin
                coef_reg <= coef_data;
            end
        end
    end

    // product of the sample just shifted in, summed by the tree
    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign sample_out = hist_reg;
    assign prod_out   = prod_reg;

endmodule

`default_nettype wire

/* rtl/lcf_adder_tree.sv */
// registered binary adder tree over the tap products
`default_nettype none

module lcf_adder_tree #(
    parameter int NUM_LEAVES = lcf_pkg::MAX_TAPS_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic [lcf_pkg::DATA_W-1:0] leaf [NUM_LEAVES],
    input  wire lcf_pkg::tag_t              tag_in,
    output logic      [lcf_pkg::DATA_W-1:0] sum_out,
    output lcf_pkg::tag_t                   tag_out
);

    localparam int LEVELS = (NUM_LEAVES > 1) ? $clog2(NUM_LEAVES) : 1;
    localparam int PAD    = 1 << LEVELS;

    logic [lcf_pkg::DATA_W-1:0] node_reg [1:PAD-1];
    logic [lcf_pkg::DATA_W-1:0] all_val  [1:2*PAD-1];
    lcf_pkg::tag_t              tag_reg  [LEVELS];

    genvar g;
    generate
        for (g = 1; g < 2*PAD; g++) begin : g_val
            if (g < PAD) begin : g_node
                assign all_val[g] = node_reg[g];
            end else if (g - PAD < NUM_LEAVES) begin : g_leaf
                assign all_val[g] = leaf[g-PAD];
            end else begin : g_pad
                assign all_val[g] = '0;
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        for (int i = 1; i < PAD; i++) begin
            node_reg[i] <= all_val[2*i] + all_val[2*i+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LEVELS; i++) begin
                tag_reg[i] <= '0;
            end
        end else begin
            tag_reg[0] <= tag_in;
            for (int i = 1; i < LEVELS; i++) begin
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    assign sum_out = node_reg[1];
    assign tag_out = tag_reg[LEVELS-1];

endmodule

`default_nettype wire

/* rtl/lcf_out_fifo.sv */
// small result queue in front of the master side
`default_nettype none

module lcf_out_fifo #(
    parameter int DEPTH = 8
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       wr_en,
    input  wire logic [lcf_pkg::DATA_W-1:0] wr_result,
    input  wire logic                       wr_last,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic      [lcf_pkg::DATA_W-1:0] m_tdata,
    output logic                            m_tlast
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [lcf_pkg::DATA_W-1:0] result_mem [DEPTH];
    logic                       last_mem   [DEPTH];
    logic [AW-1:0]              wr_ptr_reg;
    logic [AW-1:0]              wr_ptr_next;
    logic [AW-1:0]              rd_ptr_reg;
    logic [AW-1:0]              rd_ptr_next;
    logic [AW:0]                count_reg;
    logic [AW:0]                count_next;
    logic                       rd_en;

    assign rd_en = m_tvalid && m_tready;

    always_comb begin
        wr_ptr_next = wr_en ? wr_ptr_reg + AW'(1) : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        count_next  = count_reg + (AW+1)'(wr_en) - (AW+1)'(rd_en);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            result_mem[wr_ptr_reg] <= wr_result;
            last_mem[wr_ptr_reg]   <= wr_last;
        end
    end

    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = result_mem[rd_ptr_reg];
    assign m_tlast  = last_mem[rd_ptr_reg];

endmodule

`default_nettype wire

/* bench/lcf_checker.sv */
// checker for the linear convolution fir: tracks the filter state, predicts results and compares
`timescale 1ns / 100ps

module lcf_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [lcf_pkg::KLEN_W-1:0]    cfg_wr_data,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [lcf_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tlast,
    input  logic [0:0]                    s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [lcf_pkg::DATA_W-1:0]    m_tdata,
    input  logic                          m_tlast,
    output int                            fail_count,
    output int                            pending
);
    import lcf_pkg::*;

    localparam int TAPS = MAX_TAPS_DEF;

    typedef struct packed {
        logic [DATA_W-1:0] word;
        logic              last;
    } conv_out_t;

    logic [DATA_W-1:0] history [TAPS];
    logic [DATA_W-1:0] coefs [TAPS];
    logic [KLEN_W-1:0] kernel_len;
    conv_out_t         conv_queue [$];

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic int active_taps();
        if (kernel_len < 1)
            return 1;
        if (kernel_len > TAPS)
            return TAPS;
        return int'(kernel_len);
    endfunction

    function automatic void shift_history(logic [DATA_W-1:0] x);
        for (int j = TAPS - 1; j > 0; j--)
            history[j] = history[j-1];
        history[0] = x;
    endfunction

    function automatic logic [DATA_W-1:0] tap_total(int taps);
        logic [DATA_W-1:0] acc;
        acc = '0;
        for (int j = 0; j < taps; j++)
            acc = acc + coefs[j] * history[j];
        return acc;
    endfunction

    // one sample transfer: its own result, and on a last sample the zero flush
    function automatic void convolve_sample(logic [DATA_W-1:0] x, logic last);
        int taps;
        taps = active_taps();
        shift_history(x);
        conv_queue.push_back({tap_total(taps), last && taps == 1});
        if (last) begin
            for (int f = 1; f < taps; f++) begin
                shift_history('0);
                conv_queue.push_back({tap_total(taps), f == taps - 1});
            end
            for (int j = 0; j < TAPS; j++)
                history[j] = '0;
        end
    endfunction

    always @(posedge aclk) begin
        conv_out_t want;
        if (!aresetn) begin
            for (int j = 0; j < TAPS; j++) begin
                history[j] = '0;
                coefs[j]   = '0;
            end
            kernel_len = 1;
            conv_queue.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (conv_queue.size() == 0) begin
                    $display("%0t: unexpected result transfer: actual word %h last %b",
                             $time, m_tdata, m_tlast);
                    fail_count++;
                end else begin
                    want = conv_queue.pop_front();
                    if (m_tdata !== want.word) begin
                        $display("%0t: result word mismatch: expected %h actual %h",
                                 $time, want.word, m_tdata);
                        fail_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $display("%0t: result last mismatch: expected %b actual %b",
                                 $time, want.last, m_tlast);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (cmd_t'(s_tuser) == CMD_LOAD)
                    coefs[s_tdata[DATA_W +: IDX_W]] = s_tdata[DATA_W-1:0];
                else
                    convolve_sample(s_tdata[DATA_W-1:0], s_tlast);
            end
            if (cfg_wr_en)
                kernel_len = cfg_wr_data;
        end
        pending <= conv_queue.size();
    end

endmodule

/* bench/tb_top.sv */
// testbench top for the linear convolution fir: stimulus, flow control and verdict
`timescale 1ns / 100ps

module tb_top;
    import lcf_pkg::*;

    localparam int SETTLE_CYCLES = 20;

    logic                   aclk        = 1'b0;
    logic                   aresetn     = 1'b0;
    logic                   cfg_wr_en   = 1'b0;
    logic [KLEN_W-1:0]      cfg_wr_data = '0;
    logic                   s_tvalid    = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata     = '0;  // value, coef_index, zero fill
    logic                   s_tlast     = 1'b0;  // last_sample
    logic [0:0]             s_tuser     = '0;  // command
    logic                   m_tvalid;
    logic                   m_tready    = 1'b0;
    logic [DATA_W-1:0]      m_tdata;  // result
    logic                   m_tlast;  // last_result

    int fail_count;
    int pending;
    int src_idle_pct  = 0;
    int sink_stall_pct = 0;

    always #5 aclk = ~aclk;

    linear_convolution_fir u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    lcf_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= sink_stall_pct);

    // called at a clock edge; returns at the edge where the transfer happened
    task automatic send_item(input cmd_t cmd, input logic [DATA_W-1:0] val,
                             input logic [IDX_W-1:0] idx, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - DATA_W - IDX_W){1'b0}}, idx, val};
        s_tuser  <= cmd;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    task automatic send_sample(input logic [DATA_W-1:0] val, input logic last);
        send_item(CMD_SAMPLE, val, IDX_W'($urandom), last);
    endtask

    task automatic send_load(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val,
                             input logic last);
        send_item(CMD_LOAD, val, idx, last);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_kernel_length(input logic [KLEN_W-1:0] len);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [DATA_W-1:0] rand_word();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return DATA_W'($urandom_range(15));
            default: return $urandom;
        endcase
    endfunction

    task automatic random_phase(input int n_items);
        int sent;
        int seq_len;
        int pick;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            if (pick < 15) begin
                send_load(IDX_W'($urandom), rand_word(), 1'($urandom));
                sent++;
            end else if (pick < 20) begin
                // partial sequence, then a new kernel length over the held samples
                seq_len = $urandom_range(1, 4);
                for (int k = 0; k < seq_len; k++)
                    send_sample(rand_word(), 1'b0);
                sent += seq_len;
                set_kernel_length(KLEN_W'($urandom_range(0, 31)));
            end else begin
                seq_len = $urandom_range(1, 6);
                for (int k = 0; k < seq_len; k++)
                    send_sample(rand_word(), k == seq_len - 1);
                sent += seq_len;
            end
        end
    endtask

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // default single tap, then loads including a marked load
        send_load(4'd0, 32'd3, 1'b0);
        send_load(4'd15, 32'hFFFF_FFFF, 1'b0);
        send_load(4'd1, 32'hFFFF_FFFF, 1'b1);
        send_load(4'd7, 32'h8000_0001, 1'b0);
        send_load(4'd4, 32'hDEAD_BEEF, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b0);
        send_sample(32'd7, 1'b1);

        set_kernel_length(5'd16);
        send_sample(32'd0, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b0);
        send_sample(32'd1, 1'b1);

        // zero length acts as one tap, oversize saturates
        set_kernel_length(5'd0);
        send_sample(32'd2, 1'b1);
        set_kernel_length(5'd31);
        send_sample(32'hFFFF_FFFF, 1'b1);

        // length change with samples still in the delay line
        set_kernel_length(5'd3);
        send_sample(32'h1234_5678, 1'b0);
        send_sample(32'hFFFF_FFFE, 1'b0);
        set_kernel_length(5'd5);
        send_sample(32'h0000_0009, 1'b1);
        set_kernel_length(5'd17);
        send_sample(32'h8000_0000, 1'b1);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: set_kernel_length(5'd16);
                1: set_kernel_length(5'd1);
                2: set_kernel_length(5'd31);
                default: set_kernel_length(KLEN_W'($urandom_range(2, 15)));
            endcase
            src_idle_pct   = (phase == 1) ? 54 : (phase == 3) ? 31 : 0;
            sink_stall_pct = (phase == 2) ? 54 : (phase == 3) ? 31 : 0;
            random_phase(50);
        end

        src_idle_pct   = 0;
        sink_stall_pct = 0;
        drain();
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* sim.f */
rtl/lcf_pkg.sv
rtl/lcf_tap_cell.sv
rtl/lcf_adder_tree.sv
rtl/lcf_out_fifo.sv
rtl/linear_convolution_fir.sv
bench/lcf_checker.sv
bench/tb_top.sv
